// ===== design/asr_pkg.sv =====
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants of the alarm schedule table: item and result
// layouts, the stored entry layout, item kinds and register indexes.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam logic [7:0]  HOUR_LIMIT       = 8'd23;
  localparam logic [7:0]  MINUTE_LIMIT     = 8'd59;
  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;

  localparam logic [31:0] RETRIGGER_RESET  = 32'd65000;
  localparam logic [7:0]  TRACK_MAX_RESET  = 8'd99;
  localparam logic [2:0]  LOOP_MAX_RESET   = 3'd7;
  localparam logic [4:0]  VOLUME_MAX_RESET = 5'd30;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_EDIT   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_RETRIGGER  = 2'd0,
    REG_TRACK_MAX  = 2'd1,
    REG_LOOP_MAX   = 2'd2,
    REG_VOLUME_MAX = 2'd3
  } reg_index_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] entry_id;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  track;
    logic [7:0]  loop_count;
    logic [7:0]  volume;
    logic        enable;
    logic        time_valid;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        fired;
    logic [7:0]  fired_track;
    logic [2:0]  fired_loop;
    logic [4:0]  fired_volume;
    logic [31:0] assigned_id;
    logic [8:0]  entries_used;
  } result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  track;
    logic [2:0]  loop_cnt;
    logic [4:0]  volume;
    logic        enabled;
  } entry_t;

endpackage

// ===== design/alarm_schedule_table_core.sv =====
// ----------------------------------------------------------------------------
// alarm_schedule_table_core
// Daily alarm table: add, edit, delete and tick items over entries kept in
// one memory, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Each item reads every entry in use from the memory once; a delete then reads
//   the entries after the deleted one again and moves each down one place.
// Throughput: one item at a time; busy is already low in the cycle of done.
// Reset: rst (synchronous) empties the table, sets the next id to one, forgets
//   the last fired minute and loads register defaults; memory is not cleared.
// The result is shown for exactly one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module alarm_schedule_table_core
  import asr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_index_t  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT
  } state_t;

  state_t state;

  // registers
  logic [31:0] retrigger_window_ms;
  logic [7:0]  track_max;
  logic [2:0]  loop_max;
  logic [4:0]  volume_max;

  // table bookkeeping
  logic [CW-1:0] used_count;
  logic [31:0]   next_free_id;
  logic [10:0]   last_key;
  logic          last_key_valid;
  logic [31:0]   last_fire_ms;

  // per-item working registers
  item_t         cur;
  logic [CW-1:0] ptr;          // next entry to read
  logic          rd_pend;      // memory data for rd_idx arrives this cycle
  logic [IW-1:0] rd_idx;
  logic          found;
  logic [IW-1:0] found_idx;
  logic          clash_hit;
  logic [7:0]    cap_track;
  logic [2:0]    cap_loop;
  logic [4:0]    cap_volume;

  // memory ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  entry_t        ram_rdata;

  asr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Hold register writes off while an item is in flight.
  assign cfg_ready = (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);

  // --------------------------------------------------------------------------
  // Per-entry compare on the data coming back from the memory
  // --------------------------------------------------------------------------
  logic [31:0] skip_id;
  logic        time_hit;
  logic        want_hit;

  always_comb begin
    // An add skips id zero in the clash check, an edit skips its own id.
    skip_id  = (cur.kind == KIND_ADD) ? 32'd0 : cur.entry_id;
    time_hit = ({3'b000, ram_rdata.hour} == cur.hour) &&
               ({2'b00, ram_rdata.minute} == cur.minute);
    // Tick looks for the first enabled entry on this minute; edit and delete
    // look for the first entry with the given id.
    if (cur.kind == KIND_TICK) begin
      want_hit = ram_rdata.enabled && time_hit;
    end else begin
      want_hit = (ram_rdata.id == cur.entry_id);
    end
  end

  // --------------------------------------------------------------------------
  // Item checks, clamps and the retrigger window
  // --------------------------------------------------------------------------
  logic        fields_ok;
  logic        time_ok;
  logic [7:0]  loop_floor;
  logic [2:0]  loop_clamped;
  logic [4:0]  volume_sat;
  logic [10:0] tick_key;
  logic [31:0] since_fire;
  logic        blocked;
  logic        add_ok;
  logic        edit_ok;
  logic        fire;

  always_comb begin
    time_ok      = (cur.hour <= HOUR_LIMIT) && (cur.minute <= MINUTE_LIMIT);
    fields_ok    = time_ok && (cur.track != 8'd0) && (cur.track <= track_max);
    loop_floor   = (cur.loop_count == 8'd0) ? 8'd1 : cur.loop_count;
    loop_clamped = (loop_floor > {5'b00000, loop_max}) ? loop_max : loop_floor[2:0];
    volume_sat   = (cur.volume > {3'b000, volume_max}) ? volume_max : cur.volume[4:0];
    tick_key     = 11'(cur.hour[4:0]) * MINUTES_PER_HOUR + 11'(cur.minute[5:0]);
    since_fire   = cur.now_ms - last_fire_ms;
    blocked      = last_key_valid && (last_key == tick_key) &&
                   (since_fire < retrigger_window_ms);
    add_ok       = (used_count < DEPTH_COUNT) && fields_ok && !clash_hit;
    edit_ok      = fields_ok && !clash_hit && found;
    fire         = cur.time_valid && time_ok && !blocked && found;
  end

  // Result of the item as decided at the end of the scan.
  result_t result_next;

  always_comb begin
    result_next              = '0;
    result_next.entries_used = 9'(used_count);
    case (cur.kind)
      KIND_ADD: begin
        if (add_ok) begin
          result_next.accepted     = 1'b1;
          result_next.assigned_id  = next_free_id;
          result_next.entries_used = 9'(used_count) + 9'd1;
        end
      end
      KIND_EDIT: begin
        result_next.accepted = edit_ok;
      end
      KIND_DELETE: begin
        result_next.accepted = 1'b0;
      end
      default: begin
        if (fire) begin
          result_next.fired        = 1'b1;
          result_next.fired_track  = cap_track;
          result_next.fired_loop   = cap_loop;
          result_next.fired_volume = cap_volume;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory access: reads stream during scan and shift, writes land on decide
  // (add or edit) and during the shift (move each entry down one place).
  // --------------------------------------------------------------------------
  always_comb begin
    ram_re    = ((state == ST_SCAN) || (state == ST_SHIFT)) && (ptr < used_count);
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = ram_rdata;
    case (state)
      ST_DECIDE: begin
        ram_wdata.hour     = cur.hour[4:0];
        ram_wdata.minute   = cur.minute[5:0];
        ram_wdata.track    = cur.track;
        ram_wdata.loop_cnt = loop_clamped;
        ram_wdata.volume   = volume_sat;
        if (cur.kind == KIND_ADD) begin
          ram_we            = add_ok;
          ram_waddr         = used_count[IW-1:0];
          ram_wdata.id      = next_free_id;
          ram_wdata.enabled = 1'b1;
        end else begin
          ram_we            = (cur.kind == KIND_EDIT) && edit_ok;
          ram_waddr         = found_idx;
          ram_wdata.id      = cur.entry_id;
          ram_wdata.enabled = cur.enable;
        end
      end
      ST_SHIFT: begin
        // Entry rd_idx arrives now; drop it into the place below.
        ram_we    = rd_pend;
        ram_waddr = rd_idx - IW'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, bookkeeping, registers and the result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      used_count          <= '0;
      next_free_id        <= 32'd1;
      last_key            <= '0;
      last_key_valid      <= 1'b0;
      last_fire_ms        <= '0;
      retrigger_window_ms <= RETRIGGER_RESET;
      track_max           <= TRACK_MAX_RESET;
      loop_max            <= LOOP_MAX_RESET;
      volume_max          <= VOLUME_MAX_RESET;
      rd_pend             <= 1'b0;
      done                <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RETRIGGER:  retrigger_window_ms <= cfg_data;
          REG_TRACK_MAX:  track_max           <= cfg_data[7:0];
          REG_LOOP_MAX:   loop_max            <= cfg_data[2:0];
          REG_VOLUME_MAX: volume_max          <= cfg_data[4:0];
          default:        track_max           <= track_max;
        endcase
      end

      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cur       <= item;
            ptr       <= '0;
            rd_pend   <= 1'b0;
            found     <= 1'b0;
            clash_hit <= 1'b0;
            state     <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          done <= 1'b0;
          // Issue one read per cycle, evaluate each entry in the cycle after its read.
          if (ram_re) begin
            ptr    <= ptr + CW'(1);
            rd_idx <= ptr[IW-1:0];
          end
          rd_pend <= ram_re;
          if (rd_pend) begin
            if (!found && want_hit) begin
              found      <= 1'b1;
              found_idx  <= rd_idx;
              cap_track  <= ram_rdata.track;
              cap_loop   <= ram_rdata.loop_cnt;
              cap_volume <= ram_rdata.volume;
            end
            if (time_hit && (ram_rdata.id != skip_id)) begin
              clash_hit <= 1'b1;
            end
          end
          if (!ram_re && !rd_pend) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          result <= result_next;
          if ((cur.kind == KIND_DELETE) && found) begin
            // Hold the result until the later entries have moved down.
            done    <= 1'b0;
            ptr     <= CW'(found_idx) + CW'(1);
            rd_pend <= 1'b0;
            state   <= ST_SHIFT;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
          if ((cur.kind == KIND_ADD) && add_ok) begin
            used_count   <= used_count + CW'(1);
            next_free_id <= next_free_id + 32'd1;
          end
          if ((cur.kind == KIND_TICK) && fire) begin
            last_key       <= tick_key;
            last_key_valid <= 1'b1;
            last_fire_ms   <= cur.now_ms;
          end
        end

        ST_SHIFT: begin
          if (ram_re) begin
            ptr    <= ptr + CW'(1);
            rd_idx <= ptr[IW-1:0];
          end
          rd_pend <= ram_re;
          done    <= !ram_re && !rd_pend;
          if (!ram_re && !rd_pend) begin
            used_count <= used_count - CW'(1);
            result     <= '{accepted: 1'b1, fired: 1'b0, fired_track: 8'd0,
                            fired_loop: 3'd0, fired_volume: 5'd0, assigned_id: 32'd0,
                            entries_used: 9'(used_count) - 9'd1};
            state      <= ST_IDLE;
          end
        end

        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= DEPTH_COUNT)
    else $error("entry count above table depth");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state == ST_DECIDE) || $past(state == ST_SHIFT))
    else $error("result strobe without a finished item");

  a_fire_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.fired && result.accepted))
    else $error("tick result also marked accepted");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_DECIDE) || (state == ST_SHIFT))
    else $error("table written outside decide or shift");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

endmodule

// ===== design/asr_ram.sv =====
// ----------------------------------------------------------------------------
// asr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module asr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
